// ===== design/catmull_rom_segment_subdivider_top_defines.svh =====
// Assertion macros for the Catmull-Rom segment subdivider.
// Included by the RTL files that carry concurrent assertions.
`ifndef CATMULL_ROM_SEGMENT_SUBDIVIDER_TOP_DEFINES_SVH
`define CATMULL_ROM_SEGMENT_SUBDIVIDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/crss_pkg.sv =====
// Package of the Catmull-Rom segment subdivider: widths, constants and item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crss_pkg;
  localparam int unsigned COORD_BITS    = 20;
  localparam int unsigned MAX_STEPS     = 63;
  localparam int unsigned SPACING_W     = 12;
  localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd48;
  localparam int unsigned DIFF_CLAMP_W  = 21;
  localparam int unsigned MUL_B_W       = 22;
  localparam int unsigned DIV_NUM_W     = 22;
  localparam int unsigned FRAC_W        = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point0_x;
    coord_t point0_y;
    coord_t point1_x;
    coord_t point1_y;
    coord_t point2_x;
    coord_t point2_y;
    coord_t point3_x;
    coord_t point3_y;
    logic   last_segment;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   run_end;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/catmull_rom_segment_subdivider_top.sv =====
// Catmull-Rom segment subdivider: one shared multiplier, divider and root step
// under a one-hot sequencer. Depends on crss_pkg and the defines header.
// After accept: square both chord differences and sum them, take the root, divide it
// by spacing for the step count, then per point: divide for u, 6 Horner multiplies, emit.
// With last_segment, point2 follows as a closing point. Busy meanwhile, so no new item is
// taken until the last point is out. Reset clears the sequencer and output strobe; spacing
// returns to 48.
`timescale 1ns / 1ps
`default_nettype none
`include "catmull_rom_segment_subdivider_top_defines.svh"
module catmull_rom_segment_subdivider_top #(
  parameter int unsigned MAX_STEPS = crss_pkg::MAX_STEPS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [crss_pkg::SPACING_W-1:0] cfg_wdata_i,
  input  wire logic                           start,
  input  crss_pkg::in_item_t                  in_item_i,
  output logic                                busy,
  output logic                                out_valid_o,
  output crss_pkg::out_item_t                 out_item_o
);
  import crss_pkg::*;

  localparam int unsigned CW     = COORD_BITS + 5;
  localparam int unsigned DW     = COORD_BITS + 1;
  localparam int unsigned AW     = (DW > DIFF_CLAMP_W) ? DW : DIFF_CLAMP_W;
  localparam int unsigned MA     = (CW > MUL_B_W) ? CW : MUL_B_W;
  localparam int unsigned PW     = MA + MUL_B_W;
  localparam int unsigned SW     = $clog2(MAX_STEPS + 1);
  localparam int unsigned SQW    = 2 * DIFF_CLAMP_W;
  localparam int unsigned ROOT_W = DIFF_CLAMP_W;
  localparam int unsigned REM_W  = ROOT_W + 4;
  localparam int unsigned CNT_W  = $clog2(DIV_NUM_W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQ    = 8'b0000_0010,
    S_ROOT  = 8'b0000_0100,
    S_DSTEP = 8'b0000_1000,
    S_DU    = 8'b0001_0000,
    S_HORN  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_LAST  = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [SPACING_W-1:0]  spacing_q;
  coord_t                pts_q [8];
  logic                  last_q;
  logic [SQW-1:0]        sumsq_q, sumsq_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [DIV_NUM_W-1:0]  dnum_q, dnum_d, dquo_q, dquo_d;
  logic [SPACING_W:0]    drem_q, drem_d;
  logic [SPACING_W-1:0]  dden_q, dden_d;
  logic [SW-1:0]         steps_q, steps_d, s_q, s_d;
  logic [FRAC_W-1:0]     u_q, u_d;
  logic signed [CW-1:0]  acc_q [2];
  logic signed [CW-1:0]  acc_d [2];
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic signed [CW-1:0]  a0 [2], a1 [2], a2 [2], a3 [2];
  logic signed [CW-1:0]  e0 [2], e1 [2], e2 [2], e3 [2];
  logic signed [DW-1:0]  diff [2];
  logic [DW-1:0]         mag [2];
  logic [AW-1:0]         magw [2];
  logic [DIFF_CLAMP_W-1:0] dabs [2];
  logic signed [MA-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]  prod, rnd_full, half_c;
  logic signed [CW-1:0]  rnd, coef_n, fin [2];
  coord_t                sat [2];
  logic [REM_W-1:0]      rtrial, rshift;
  logic [SPACING_W:0]    dt, dden_x;
  logic                  dge;
  logic [DIV_NUM_W-1:0]  quo_n;
  logic                  ax;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      e0[i] = CW'(pts_q[i]);
      e1[i] = CW'(pts_q[2+i]);
      e2[i] = CW'(pts_q[4+i]);
      e3[i] = CW'(pts_q[6+i]);
      a0[i] = e1[i] <<< 1;
      a1[i] = e2[i] - e0[i];
      a2[i] = (e0[i] <<< 1) - (e1[i] <<< 2) - e1[i] + (e2[i] <<< 2) - e3[i];
      a3[i] = e3[i] - e0[i] + (e1[i] <<< 1) + e1[i] - (e2[i] <<< 1) - e2[i];
      diff[i] = DW'(pts_q[4+i]) - DW'(pts_q[2+i]);
      mag[i]  = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
      magw[i] = AW'(mag[i]);
      dabs[i] = (magw[i] > (AW'(1) << (DIFF_CLAMP_W - 1))) ?
                (DIFF_CLAMP_W'(1) << (DIFF_CLAMP_W - 1)) : magw[i][DIFF_CLAMP_W-1:0];
      fin[i]  = (acc_q[i] + CW'(1)) >>> 1;
      if (fin[i] > CW'(signed'({1'b0, {(COORD_BITS-1){1'b1}}}))) begin
        sat[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else if (fin[i] < CW'(signed'({1'b1, {(COORD_BITS-1){1'b0}}}))) begin
        sat[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        sat[i] = fin[i][COORD_BITS-1:0];
      end
    end
  end

  assign ax = cnt_q[0];

  always_comb begin
    if (state_q == S_HORN) begin
      mul_a = MA'(acc_q[ax]);
      mul_b = signed'({{(MUL_B_W-FRAC_W){1'b0}}, u_q});
    end else begin
      mul_a = signed'({{(MA-DIFF_CLAMP_W){1'b0}}, dabs[ax]});
      mul_b = signed'({{(MUL_B_W-DIFF_CLAMP_W){1'b0}}, dabs[ax]});
    end
  end

  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign half_c   = PW'(1) << (FRAC_W - 1);
  assign rnd_full = (prod + half_c) >>> FRAC_W;
  assign rnd      = rnd_full[CW-1:0];

  always_comb begin
    case (cnt_q[2:1])
      2'd0:    coef_n = a2[ax];
      2'd1:    coef_n = a1[ax];
      default: coef_n = a0[ax];
    endcase
  end

  assign rshift = {rem_q[REM_W-3:0], sumsq_q[SQW-1 -: 2]};
  assign rtrial = {2'b00, root_q, 2'b01};
  assign dden_x = {1'b0, dden_q};
  assign dt     = {drem_q[SPACING_W-1:0], dnum_q[DIV_NUM_W-1]};
  assign dge    = (dt >= dden_x);
  assign quo_n  = {dquo_q[DIV_NUM_W-2:0], dge};

  always_comb begin
    state_d     = state_q;
    sumsq_d     = sumsq_q;
    cnt_d       = cnt_q;
    root_d      = root_q;
    rem_d       = rem_q;
    dnum_d      = dnum_q;
    dquo_d      = dquo_q;
    drem_d      = drem_q;
    dden_d      = dden_q;
    steps_d     = steps_q;
    s_d         = s_q;
    u_d         = u_q;
    acc_d       = acc_q;
    out_valid_d = 1'b0;
    out_item_d  = out_item_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_SQ;
          sumsq_d = '0;
          cnt_d   = '0;
        end
      end
      S_SQ: begin
        sumsq_d = sumsq_q + prod[SQW-1:0];
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_ROOT;
          cnt_d   = '0;
          root_d  = '0;
          rem_d   = '0;
        end
      end
      S_ROOT: begin
        sumsq_d = sumsq_q << 2;
        if (rshift >= rtrial) begin
          rem_d  = rshift - rtrial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rshift;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          state_d = S_DSTEP;
          cnt_d   = '0;
          dnum_d  = DIV_NUM_W'(root_d);
          drem_d  = '0;
          dquo_d  = '0;
          dden_d  = (spacing_q == '0) ? SPACING_W'(1) : spacing_q;
        end
      end
      S_DSTEP, S_DU: begin
        drem_d = dge ? (dt - dden_x) : dt;
        dquo_d = quo_n;
        dnum_d = dnum_q << 1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          cnt_d = '0;
          if (state_q == S_DSTEP) begin
            if (quo_n == '0) begin
              steps_d = SW'(1);
            end else if (quo_n > DIV_NUM_W'(MAX_STEPS)) begin
              steps_d = SW'(MAX_STEPS);
            end else begin
              steps_d = quo_n[SW-1:0];
            end
            s_d     = '0;
            state_d = S_DU;
            dnum_d  = '0;
            drem_d  = '0;
            dquo_d  = '0;
            dden_d  = SPACING_W'(steps_d);
          end else begin
            u_d     = quo_n[FRAC_W-1:0];
            acc_d   = a3;
            state_d = S_HORN;
          end
        end
      end
      S_HORN: begin
        acc_d[ax] = coef_n + rnd;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(5)) begin
          state_d = S_EMIT;
          cnt_d   = '0;
        end
      end
      S_EMIT: begin
        out_valid_d        = 1'b1;
        out_item_d.out_x   = sat[0];
        out_item_d.out_y   = sat[1];
        out_item_d.run_end = (s_q + SW'(1) == steps_q) && !last_q;
        if (s_q + SW'(1) == steps_q) begin
          state_d = last_q ? S_LAST : S_IDLE;
        end else begin
          s_d     = s_q + SW'(1);
          state_d = S_DU;
          dnum_d  = DIV_NUM_W'({s_d, {FRAC_W{1'b0}}});
          drem_d  = '0;
          dquo_d  = '0;
        end
      end
      S_LAST: begin
        out_valid_d        = 1'b1;
        out_item_d.out_x   = pts_q[4];
        out_item_d.out_y   = pts_q[5];
        out_item_d.run_end = 1'b1;
        state_d            = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spacing_q   <= SPACING_RESET;
      cnt_q       <= '0;
      steps_q     <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        spacing_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sumsq_q    <= sumsq_d;
    root_q     <= root_d;
    rem_q      <= rem_d;
    dnum_q     <= dnum_d;
    dquo_q     <= dquo_d;
    drem_q     <= drem_d;
    dden_q     <= dden_d;
    u_q        <= u_d;
    acc_q      <= acc_d;
    out_item_q <= out_item_d;
    if (state_q == S_IDLE && start) begin
      pts_q[0] <= in_item_i.point0_x;
      pts_q[1] <= in_item_i.point0_y;
      pts_q[2] <= in_item_i.point1_x;
      pts_q[3] <= in_item_i.point1_y;
      pts_q[4] <= in_item_i.point2_x;
      pts_q[5] <= in_item_i.point2_y;
      pts_q[6] <= in_item_i.point3_x;
      pts_q[7] <= in_item_i.point3_y;
      last_q   <= in_item_i.last_segment;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `CRS_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "accepted item not busy")
  `CRS_ASSERT(a_strobe_src, clk_i, rst_ni, out_valid_o |-> $past(state_q == S_EMIT || state_q == S_LAST), "strobe without emit")
  `CRS_ASSERT(a_end_idle, clk_i, rst_ni, out_valid_o && out_item_o.run_end |-> !busy, "run end while busy")
  `CRS_ASSERT(a_step_rng, clk_i, rst_ni, state_q == S_HORN |-> (steps_q != '0 && steps_q <= SW'(MAX_STEPS) && s_q < steps_q), "step out of range")
  `CRS_ASSERT(a_cnt_rng, clk_i, rst_ni, cnt_q <= CNT_W'(DIV_NUM_W - 1), "counter out of range")
  `CRS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "strobe after reset")
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench of the Catmull-Rom segment subdivider: random and directed segments,
// predicted point by point and checked against the output strobe.
// Depends on crss_pkg and catmull_rom_segment_subdivider_top.
`timescale 1ns / 1ps
module tb;
  import crss_pkg::*;

  localparam int unsigned LIMIT = 2000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [SPACING_W-1:0] cfg_wdata = '0;
  logic                 start = 1'b0;
  in_item_t             seg_in = '0;
  logic                 busy;
  logic                 pt_valid;
  out_item_t            pt_out;

  catmull_rom_segment_subdivider_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .start      (start),
    .in_item_i  (seg_in),
    .busy       (busy),
    .out_valid_o(pt_valid),
    .out_item_o (pt_out)
  );

  always #2 clk = ~clk;

  in_item_t  seg_queue[$];
  out_item_t point_queue[$];
  logic [SPACING_W-1:0] spacing_q = SPACING_RESET;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  bit          hold_drive = 1'b0;

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint eval_axis(longint p0, longint p1, longint p2, longint p3,
                                       longint u);
    longint a0, a1, a2, a3, r;
    a0 = 2 * p1;
    a1 = p2 - p0;
    a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    a3 = -p0 + 3 * p1 - 3 * p2 + p3;
    r = a2 + floor16(a3 * u + 32768);
    r = a1 + floor16(r * u + 32768);
    r = a0 + floor16(r * u + 32768);
    return floor16((r + 1) * 32768);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return coord_t'(v);
  endfunction

  function automatic longint root_floor(longint n);
    longint r;
    r = longint'($sqrt(real'(n)));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic longint clamp_diff(longint d);
    if (d < 0) d = -d;
    return d > (64'sd1 << 20) ? (64'sd1 << 20) : d;
  endfunction

  task automatic predict_points(in_item_t it);
    longint dx, dy, len, sp, q, u;
    out_item_t o;
    dx = clamp_diff(longint'(it.point2_x) - longint'(it.point1_x));
    dy = clamp_diff(longint'(it.point2_y) - longint'(it.point1_y));
    len = root_floor(dx * dx + dy * dy);
    sp = (spacing_q == 0) ? 1 : spacing_q;
    q = len / sp;
    if (q < 1) q = 1;
    if (q > MAX_STEPS) q = MAX_STEPS;
    for (longint s = 0; s < q; s++) begin
      u = (s << 16) / q;
      o.out_x = clamp_coord(eval_axis(it.point0_x, it.point1_x, it.point2_x, it.point3_x, u));
      o.out_y = clamp_coord(eval_axis(it.point0_y, it.point1_y, it.point2_y, it.point3_y, u));
      o.run_end = !it.last_segment && (s + 1 == q);
      point_queue = {point_queue, o};
    end
    if (it.last_segment) begin
      o.out_x = it.point2_x;
      o.out_y = it.point2_y;
      o.run_end = 1'b1;
      point_queue = {point_queue, o};
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_points(seg_in);
        void'(seg_queue.pop_front());
      end
      if (start && busy) begin
      end else if (!hold_drive && seg_queue.size() > 0 && !(start && !busy && 0) &&
                   $urandom_range(99) >= idle_pct) begin
        if (start && !busy) begin
          if (seg_queue.size() > 0) begin
            start  <= 1'b1;
            seg_in <= seg_queue[0];
          end else begin
            start <= 1'b0;
          end
        end else begin
          start  <= 1'b1;
          seg_in <= seg_queue[0];
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n && pt_valid) begin
      if (point_queue.size() == 0) begin
        report_mismatch("unexpected point", pt_out.out_x, 0);
      end else begin
        out_item_t e;
        e = point_queue.pop_front();
        if (pt_out.out_x !== e.out_x) report_mismatch("out_x", pt_out.out_x, e.out_x);
        if (pt_out.out_y !== e.out_y) report_mismatch("out_y", pt_out.out_y, e.out_y);
        if (pt_out.run_end !== e.run_end) report_mismatch("run_end", pt_out.run_end, e.run_end);
      end
    end
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(400) - 200);
      default: return coord_t'($urandom_range(8000) - 4000);
    endcase
  endfunction

  function automatic in_item_t rand_seg();
    in_item_t it;
    int m;
    coord_t bx, by;
    m = $urandom_range(9);
    bx = coord_t'($urandom);
    by = coord_t'($urandom);
    if (m == 0) begin
      it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      it.point0_x = bx + rand_coord(m > 5 ? 1 : 2);
      it.point0_y = by + rand_coord(m > 5 ? 1 : 2);
      it.point1_x = bx + rand_coord(m > 5 ? 1 : 2);
      it.point1_y = by + rand_coord(m > 5 ? 1 : 2);
      it.point2_x = bx + rand_coord(m > 5 ? 1 : 2);
      it.point2_y = by + rand_coord(m > 5 ? 1 : 2);
      it.point3_x = bx + rand_coord(m > 5 ? 1 : 2);
      it.point3_y = by + rand_coord(m > 5 ? 1 : 2);
      it.last_segment = 1'($urandom_range(1));
    end
    return it;
  endfunction

  function automatic in_item_t make_seg(int a, int b, int c, int d, bit last);
    in_item_t it;
    it.point0_x = coord_t'(a); it.point0_y = coord_t'(-a);
    it.point1_x = coord_t'(b); it.point1_y = coord_t'(b);
    it.point2_x = coord_t'(c); it.point2_y = coord_t'(-c);
    it.point3_x = coord_t'(d); it.point3_y = coord_t'(d);
    it.last_segment = last;
    return it;
  endfunction

  task automatic drain();
    while (seg_queue.size() > 0 || start || busy || point_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_spacing(logic [SPACING_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    spacing_q = v;
    @(posedge clk);
  endtask

  initial begin
    int pcts[4] = '{0, 83, 0, 38};
    logic [SPACING_W-1:0] sps[4] = '{12'd1, 12'd4095, 12'd0, 12'd300};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, zero chord, huge chord, saturation
    seg_queue = {seg_queue, make_seg(0, 0, 0, 0, 1'b0)};
    seg_queue = {seg_queue, make_seg(0, 0, 0, 0, 1'b1)};
    seg_queue = {seg_queue, make_seg(-524288, -524288, 524287, 524287, 1'b0)};
    seg_queue = {seg_queue, make_seg(524287, 524287, -524288, -524288, 1'b1)};
    seg_queue = {seg_queue, make_seg(524287, -524288, 524287, -524288, 1'b1)};
    seg_queue = {seg_queue, make_seg(-524288, 524287, -524288, 524287, 1'b0)};
    seg_queue = {seg_queue, make_seg(-1, -1, -1, -1, 1'b1)};
    seg_queue = {seg_queue, make_seg(100, 0, 47, 200, 1'b0)};
    seg_queue = {seg_queue, make_seg(-100, 0, 48, -300, 1'b1)};
    seg_queue = {seg_queue, make_seg(0, 100, 800, 900, 1'b0)};
    drain();
    foreach (sps[p]) begin
      write_spacing(sps[p]);
      idle_pct = pcts[p];
      for (int i = 0; i < 35; i++) seg_queue = {seg_queue, rand_seg()};
      drain();
    end
    write_spacing(12'd48);
    for (int i = 0; i < 110; i++) begin
      idle_pct = (i < 40) ? 83 : ((i < 80) ? 38 : 0);
      if (i == 60) begin
        while (seg_queue.size() > 0) @(posedge clk);
        hold_drive = 1'b1;
        drain();
        hold_drive = 1'b0;
      end
      seg_queue = {seg_queue, rand_seg()};
      while (seg_queue.size() > 2) @(posedge clk);
    end
    drain();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
